FILE: rtl/rsp_pkg.sv
package rsp_pkg;

  localparam int LANES      = 8;
  localparam int BYTE_W     = 8;
  localparam int STRIPE_W   = 24;
  localparam int OFFSET_W   = 16;
  localparam int COUNT_W    = 4;
  localparam int POS_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0]  DISK_COUNT_RESET = 4'd4;
  localparam logic [OFFSET_W-1:0] BLOCK_SIZE_RESET = 16'd1024;
  localparam logic [COUNT_W-1:0]  MIN_DISKS        = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISK_COUNT  = 2'd0,
    REG_BLOCK_SIZE  = 2'd1,
    REG_DECODE_MODE = 2'd2
  } cfg_reg_t;

  typedef logic [LANES-1:0][BYTE_W-1:0] byte_vec_t;

  typedef struct packed {
    logic [BYTE_W-1:0] lane_byte_0;
    logic [BYTE_W-1:0] lane_byte_1;
    logic [BYTE_W-1:0] lane_byte_2;
    logic [BYTE_W-1:0] lane_byte_3;
    logic [BYTE_W-1:0] lane_byte_4;
    logic [BYTE_W-1:0] lane_byte_5;
    logic [BYTE_W-1:0] lane_byte_6;
    logic [BYTE_W-1:0] lane_byte_7;
    logic [LANES-1:0]  missing_mask;
  } column_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte_0;
    logic [BYTE_W-1:0]   out_byte_1;
    logic [BYTE_W-1:0]   out_byte_2;
    logic [BYTE_W-1:0]   out_byte_3;
    logic [BYTE_W-1:0]   out_byte_4;
    logic [BYTE_W-1:0]   out_byte_5;
    logic [BYTE_W-1:0]   out_byte_6;
    logic [BYTE_W-1:0]   out_byte_7;
    logic [STRIPE_W-1:0] stripe_number;
    logic [OFFSET_W-1:0] byte_offset;
    logic                last_of_stripe;
    logic                error;
  } result_t;

  // Per-column control shared by every lane.
  typedef struct packed {
    logic               decode;
    logic [COUNT_W-1:0] disks;
    logic [POS_W-1:0]   parity_pos;
    logic [LANES-1:0]   missing;
    logic [BYTE_W-1:0]  rebuilt;
    logic [BYTE_W-1:0]  parity;
  } lane_ctrl_t;

  typedef struct packed {
    logic [STRIPE_W-1:0] stripe;
    logic [OFFSET_W-1:0] offset;
    logic                last;
  } col_info_t;

endpackage

FILE: rtl/rsp_stream_if.sv
interface rsp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rsp_seq.sv
module rsp_seq
  import rsp_pkg::*;
#(
  parameter int MAX_DISKS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  advance,
  output logic                  decode,
  output logic [COUNT_W-1:0]    disks,
  output logic [POS_W-1:0]      parity_pos,
  output col_info_t             info
);

  logic [COUNT_W-1:0]  disk_count;
  logic [OFFSET_W-1:0] block_size;
  logic                decode_mode;
  logic [STRIPE_W-1:0] stripe;
  logic [OFFSET_W-1:0] offset;
  logic [STRIPE_W-1:0] stripe_next;
  logic [OFFSET_W-1:0] block_end;
  logic                last;

  // Stripe number modulo every supported disk count, kept incrementally so
  // the parity disk follows a disk count change without a divider.
  logic [POS_W-1:0] resid [3:MAX_DISKS];

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_count  <= DISK_COUNT_RESET;
      block_size  <= BLOCK_SIZE_RESET;
      decode_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DISK_COUNT:  disk_count  <= cfg_data[COUNT_W-1:0];
        REG_BLOCK_SIZE:  block_size  <= cfg_data[OFFSET_W-1:0];
        REG_DECODE_MODE: decode_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (disk_count < MIN_DISKS) begin
      disks = MIN_DISKS;
    end else if (disk_count > COUNT_W'(MAX_DISKS)) begin
      disks = COUNT_W'(MAX_DISKS);
    end else begin
      disks = disk_count;
    end
    parity_pos = '0;
    for (int m = 3; m <= MAX_DISKS; m++) begin
      if (disks == COUNT_W'(m)) begin
        parity_pos = resid[m];
      end
    end
  end

  assign block_end   = (block_size == '0) ? '0 : block_size - 1'b1;
  assign last        = (offset >= block_end);
  assign stripe_next = stripe + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stripe <= '0;
      offset <= '0;
    end else if (advance) begin
      if (last) begin
        stripe <= stripe_next;
        offset <= '0;
      end else begin
        offset <= offset + 1'b1;
      end
    end
  end

  for (genvar m = 3; m <= MAX_DISKS; m++) begin : g_resid
    always_ff @(posedge clk) begin
      if (rst) begin
        resid[m] <= '0;
      end else if (advance && last) begin
        if (stripe_next == '0 || resid[m] == POS_W'(m - 1)) begin
          resid[m] <= '0;
        end else begin
          resid[m] <= resid[m] + 1'b1;
        end
      end
    end
  end

  assign decode      = decode_mode;
  assign info.stripe = stripe;
  assign info.offset = offset;
  assign info.last   = last;

endmodule

FILE: rtl/rsp_lane.sv
module rsp_lane
  import rsp_pkg::*;
#(
  parameter int LANE = 0
) (
  input  byte_vec_t         lanes,
  input  lane_ctrl_t        ctrl,
  output logic [BYTE_W-1:0] out_byte
);

  logic [POS_W-1:0]  enc_src;
  logic [POS_W-1:0]  dec_disk;
  logic [BYTE_W-1:0] enc_byte;
  logic [BYTE_W-1:0] dec_byte;

  // Encode: this lane is disk LANE; data byte index skips the parity disk.
  // Decode: this lane is data byte LANE; its disk index skips the parity disk.
  assign enc_src  = (POS_W'(LANE) > ctrl.parity_pos) ? POS_W'(LANE - 1) : POS_W'(LANE);
  assign dec_disk = (POS_W'(LANE) < ctrl.parity_pos) ? POS_W'(LANE) : POS_W'(LANE + 1);

  always_comb begin
    if (POS_W'(LANE) == ctrl.parity_pos) begin
      enc_byte = ctrl.parity;
    end else if (COUNT_W'(LANE) < ctrl.disks) begin
      enc_byte = lanes[enc_src];
    end else begin
      enc_byte = '0;
    end

    if (COUNT_W'(LANE + 1) < ctrl.disks) begin
      dec_byte = ctrl.missing[dec_disk] ? ctrl.rebuilt : lanes[dec_disk];
    end else begin
      dec_byte = '0;
    end
  end

  assign out_byte = ctrl.decode ? dec_byte : enc_byte;

endmodule

FILE: rtl/rsp_merge.sv
module rsp_merge
  import rsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  byte_vec_t  lane_bytes,
  input  col_info_t  info,
  input  logic       error,
  output logic       space,
  rsp_stream_if.source result
);

  logic    held;
  result_t held_data;

  assign space = !held || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (result.ready) begin
      held <= 1'b0;
    end
  end

  // A rejected decode column reports zeros on every byte lane.
  always_ff @(posedge clk) begin
    if (take) begin
      held_data.out_byte_0     <= error ? '0 : lane_bytes[0];
      held_data.out_byte_1     <= error ? '0 : lane_bytes[1];
      held_data.out_byte_2     <= error ? '0 : lane_bytes[2];
      held_data.out_byte_3     <= error ? '0 : lane_bytes[3];
      held_data.out_byte_4     <= error ? '0 : lane_bytes[4];
      held_data.out_byte_5     <= error ? '0 : lane_bytes[5];
      held_data.out_byte_6     <= error ? '0 : lane_bytes[6];
      held_data.out_byte_7     <= error ? '0 : lane_bytes[7];
      held_data.stripe_number  <= info.stripe;
      held_data.byte_offset    <= info.offset;
      held_data.last_of_stripe <= info.last;
      held_data.error          <= error;
    end
  end

  assign result.valid = held;
  assign result.data  = held_data;

endmodule

FILE: rtl/raid5_stripe_parity_engine_top.sv
// Channel  | Role   | Payload   | Handshake
// column   | sink   | column_t  | valid/ready, one byte column across all disks
// result   | source | result_t  | valid/ready, one output column
// cfg      | write  | 16-bit    | cfg_we with cfg_index, no back-pressure
//
// The lanes and XOR trees are combinational and settle in the cycle of the
// transaction; the result is captured in the output register at the
// accepting edge and is offered from the next cycle on.
// A new column is taken every cycle as long as the output register is empty or
// is being drained. Reset is synchronous, clears the counters and returns the
// configuration to its defaults.
// A stalled result holds the column input off until the result is taken.
module raid5_stripe_parity_engine_top
  import rsp_pkg::*;
#(
  parameter int MAX_DISKS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rsp_stream_if.sink            column,
  rsp_stream_if.source          result
);

  logic               take;
  logic               space;
  logic               decode;
  logic [COUNT_W-1:0] disks;
  logic [POS_W-1:0]   parity_pos;
  col_info_t          info;
  byte_vec_t          lanes;
  byte_vec_t          lane_bytes;
  lane_ctrl_t         ctrl;
  logic [LANES-1:0]   active;
  logic [LANES-1:0]   missing;
  logic               error;
  column_t            col;

  assign col          = column.data;
  assign column.ready = space;
  assign take         = column.valid && space;

  assign lanes[0] = col.lane_byte_0;
  assign lanes[1] = col.lane_byte_1;
  assign lanes[2] = col.lane_byte_2;
  assign lanes[3] = col.lane_byte_3;
  assign lanes[4] = col.lane_byte_4;
  assign lanes[5] = col.lane_byte_5;
  assign lanes[6] = col.lane_byte_6;
  assign lanes[7] = col.lane_byte_7;

  rsp_seq #(
    .MAX_DISKS(MAX_DISKS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (take),
    .decode    (decode),
    .disks     (disks),
    .parity_pos(parity_pos),
    .info      (info)
  );

  assign active  = LANES'((9'd1 << disks) - 9'd1);
  assign missing = col.missing_mask & active;
  assign error   = decode && ((missing & (missing - 1'b1)) != '0);

  // Parity covers the data lanes in encode; the rebuilt byte is the XOR of
  // every present disk, which leaves out the one missing disk.
  always_comb begin
    ctrl.decode     = decode;
    ctrl.disks      = disks;
    ctrl.parity_pos = parity_pos;
    ctrl.missing    = missing;
    ctrl.rebuilt    = '0;
    ctrl.parity     = '0;
    for (int k = 0; k < LANES; k++) begin
      if (active[k] && !missing[k]) begin
        ctrl.rebuilt = ctrl.rebuilt ^ lanes[k];
      end
      if (COUNT_W'(k + 1) < disks) begin
        ctrl.parity = ctrl.parity ^ lanes[k];
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    rsp_lane #(
      .LANE(k)
    ) u_lane (
      .lanes   (lanes),
      .ctrl    (ctrl),
      .out_byte(lane_bytes[k])
    );
  end

  rsp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .lane_bytes(lane_bytes),
    .info      (info),
    .error     (error),
    .space     (space),
    .result    (result)
  );

endmodule
